>>> rtl/drrip_pkg.sv
// shared constants, types and codes for the drrip replacement core
`default_nettype none
package drrip_pkg;

  localparam int NUM_SETS    = 2048;
  localparam int NUM_WAYS    = 16;
  localparam int LEADER_SETS = 32;
  localparam int SEL_W       = 10;
  localparam int RRPV_W      = 2;

  localparam int SET_W    = $clog2(NUM_SETS);
  localparam int WAY_W    = 4;
  localparam int VICTIM_W = 4;
  localparam int WORD_W   = NUM_WAYS * RRPV_W;

  localparam logic [RRPV_W-1:0] RRPV_SAT = {RRPV_W{1'b1}};
  localparam logic [RRPV_W-1:0] RRPV_LONG = RRPV_SAT - RRPV_W'(1);
  localparam logic [SEL_W-1:0] SEL_MAX = {SEL_W{1'b1}};
  localparam logic [SEL_W-1:0] SEL_HALF = SEL_MAX >> 1;

  localparam int STRIDE_RAW = NUM_SETS / LEADER_SETS;
  localparam int STRIDE     = (STRIDE_RAW == 0) ? 1 : STRIDE_RAW;
  localparam int STRIDE_SH  = $clog2(STRIDE);
  localparam int STRIDE_MID = STRIDE / 2;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic req_victim;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/drrip_cache_replacement_core.sv
// Set-dueling RRIP replacement core. A request's set word is read from the single-port set
// memory in the accept cycle and aged or updated and written back in the write-back step,
// and no new request is taken before that write-back. A victim request returns one result,
// an update none. Results sit in an output register; a victim request whose result register
// is still held by a stalled result waits in the write-back step until it is taken. After
// reset the core clears the 2048-entry set memory to the maximum re-reference value, one set
// per cycle, and keeps in_stall high until the clearing is done.
`default_nettype none
module drrip_cache_replacement_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_operation,
  input  wire logic [drrip_pkg::SET_W-1:0]    in_set_index,
  input  wire logic [drrip_pkg::WAY_W-1:0]    in_way_index,
  input  wire logic                           in_was_hit,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [drrip_pkg::VICTIM_W-1:0] out_victim_way
);

  drrip_pkg::dp_cmd_t cmd;
  drrip_pkg::dp_sts_t sts;

  drrip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  drrip_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (in_operation),
    .in_set_index   (in_set_index),
    .in_way_index   (in_way_index),
    .in_was_hit     (in_was_hit),
    .out_victim_way (out_victim_way)
  );

endmodule
`default_nettype wire

>>> rtl/drrip_datapath.sv
// set memory, policy selector, ageing and victim search
`default_nettype none
module drrip_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire drrip_pkg::dp_cmd_t                 cmd,
  output drrip_pkg::dp_sts_t                      sts,
  input  wire logic                               in_operation,
  input  wire logic [drrip_pkg::SET_W-1:0]        in_set_index,
  input  wire logic [drrip_pkg::WAY_W-1:0]        in_way_index,
  input  wire logic                               in_was_hit,
  output logic      [drrip_pkg::VICTIM_W-1:0]     out_victim_way
);

  logic [drrip_pkg::WORD_W-1:0] mem [drrip_pkg::NUM_SETS];

  logic [drrip_pkg::WORD_W-1:0]   rd_data_r;
  logic                           op_r;
  logic [drrip_pkg::SET_W-1:0]    set_r;
  logic [drrip_pkg::WAY_W-1:0]    way_r;
  logic                           hit_r;
  logic [drrip_pkg::SET_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [drrip_pkg::SEL_W-1:0]    sel_r, sel_nxt;
  logic [drrip_pkg::VICTIM_W-1:0] victim_r;

  logic                           srrip_lead, brrip_lead, way_ok;
  logic [drrip_pkg::RRPV_W-1:0]   top, add, fill_val, new_val;
  logic [drrip_pkg::NUM_WAYS-1:0] cand;
  logic [drrip_pkg::NUM_WAYS-1:0] bit_vec;
  logic [drrip_pkg::WORD_W-1:0]   aged, upd_word, wr_word;
  logic [drrip_pkg::WAY_W-1:0]    victim;
  logic [drrip_pkg::SEL_W-1:0]    sel_up;
  logic                           mem_we;
  logic [drrip_pkg::SET_W-1:0]    mem_wa;
  logic [drrip_pkg::WORD_W-1:0]   mem_wd;

  // leader roles from the set index
  always_comb begin
    logic lead_range;
    lead_range = (32'(set_r >> drrip_pkg::STRIDE_SH) < drrip_pkg::LEADER_SETS);
    srrip_lead = lead_range &&
                 (32'(set_r & drrip_pkg::SET_W'(drrip_pkg::STRIDE - 1)) == 0);
    brrip_lead = lead_range &&
                 (32'(set_r & drrip_pkg::SET_W'(drrip_pkg::STRIDE - 1)) ==
                  drrip_pkg::STRIDE_MID);
    way_ok     = (32'(way_r) < drrip_pkg::NUM_WAYS);
  end

  // highest value in the set, one bit at a time from the msb
  always_comb begin
    cand    = '1;
    top     = '0;
    bit_vec = '0;
    for (int b = drrip_pkg::RRPV_W - 1; b >= 0; b--) begin
      for (int i = 0; i < drrip_pkg::NUM_WAYS; i++) begin
        bit_vec[i] = rd_data_r[i*drrip_pkg::RRPV_W + b];
      end
      top[b] = |(cand & bit_vec);
      if (top[b]) begin
        cand = cand & bit_vec;
      end
    end
    add = drrip_pkg::RRPV_SAT - top;
  end

  // age every way, then take the lowest way at the maximum
  always_comb begin
    victim = '0;
    for (int i = 0; i < drrip_pkg::NUM_WAYS; i++) begin
      aged[i*drrip_pkg::RRPV_W +: drrip_pkg::RRPV_W] =
        rd_data_r[i*drrip_pkg::RRPV_W +: drrip_pkg::RRPV_W] + add;
    end
    for (int i = drrip_pkg::NUM_WAYS - 1; i >= 0; i--) begin
      if (aged[i*drrip_pkg::RRPV_W +: drrip_pkg::RRPV_W] == drrip_pkg::RRPV_SAT) begin
        victim = drrip_pkg::WAY_W'(i);
      end
    end
  end

  // hit or fill update of one way and the selector
  always_comb begin
    if (srrip_lead) begin
      fill_val = '0;
    end else if (brrip_lead) begin
      fill_val = drrip_pkg::RRPV_LONG;
    end else if (sel_r >= drrip_pkg::SEL_HALF) begin
      fill_val = '0;
    end else begin
      fill_val = drrip_pkg::RRPV_LONG;
    end
    new_val  = hit_r ? '0 : fill_val;
    upd_word = rd_data_r;
    for (int i = 0; i < drrip_pkg::NUM_WAYS; i++) begin
      if (way_ok && (32'(way_r) == i)) begin
        upd_word[i*drrip_pkg::RRPV_W +: drrip_pkg::RRPV_W] = new_val;
      end
    end

    sel_up = sel_r;
    if (srrip_lead && (sel_r != drrip_pkg::SEL_MAX)) begin
      sel_up = sel_r + drrip_pkg::SEL_W'(1);
    end
    sel_nxt = sel_up;
    if (brrip_lead && (sel_up != '0)) begin
      sel_nxt = sel_up - drrip_pkg::SEL_W'(1);
    end
    if (!(cmd.commit && (op_r == drrip_pkg::OP_UPDATE) && hit_r && way_ok)) begin
      sel_nxt = sel_r;
    end

    wr_word = (op_r == drrip_pkg::OP_VICTIM) ? aged : upd_word;
  end

  assign clr_cnt_nxt = cmd.clear_wr ? clr_cnt_r + drrip_pkg::SET_W'(1) : clr_cnt_r;

  assign mem_we = cmd.clear_wr || cmd.commit;
  assign mem_wa = cmd.clear_wr ? clr_cnt_r : set_r;
  assign mem_wd = cmd.clear_wr ? {drrip_pkg::WORD_W{1'b1}} : wr_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.accept) begin
      rd_data_r <= mem[in_set_index];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      set_r <= in_set_index;
      way_r <= in_way_index;
      hit_r <= in_was_hit;
    end
    if (cmd.commit && (op_r == drrip_pkg::OP_VICTIM)) begin
      victim_r <= drrip_pkg::VICTIM_W'(victim);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      sel_r     <= drrip_pkg::SEL_HALF;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      sel_r     <= sel_nxt;
    end
  end

  assign sts.clear_last = (clr_cnt_r == {drrip_pkg::SET_W{1'b1}});
  assign sts.req_victim = (op_r == drrip_pkg::OP_VICTIM);
  assign out_victim_way = victim_r;

  // selector moves only on a committed request
  a_sel_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(sel_r))
    else $error("selector changed without a commit");

  // selector never steps by more than one
  a_sel_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (sel_r == $past(sel_r)) ||
                   (sel_r == $past(sel_r) + drrip_pkg::SEL_W'(1)) ||
                   (sel_r == $past(sel_r) - drrip_pkg::SEL_W'(1)))
    else $error("selector jumped");

  // clearing and request commit never share the write port
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clear_wr && (cmd.commit || cmd.accept)))
    else $error("write port conflict");

endmodule
`default_nettype wire

>>> rtl/drrip_ctrl.sv
// request sequencer: clearing pass, read and write-back steps, result handshake
`default_nettype none
module drrip_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output drrip_pkg::dp_cmd_t      cmd,
  input  wire drrip_pkg::dp_sts_t sts
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_MODIFY = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_commit;

  // a victim result needs the output register free or leaving
  assign can_commit = !(sts.req_victim && out_valid_r && out_stall);

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.clear_wr = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit && sts.req_victim) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // no request taken while the set memory is being cleared
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("request accepted during clearing");

  // an accepted request moves straight to the write-back step
  a_accept_modify: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_MODIFY))
    else $error("accepted request lost");

  // a new result only appears right after a victim commit
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit && sts.req_victim))
    else $error("result without a victim request");

endmodule
`default_nettype wire

>>> sim/drrip_cache_replacement_core_tb.sv
// testbench for the drrip replacement core: directed and random request streams against a predictor
`timescale 1ns / 1ps
`default_nettype none
module drrip_cache_replacement_core_tb;
  import drrip_pkg::*;

  typedef struct packed {
    logic              op;
    logic [SET_W-1:0]  set;
    logic [WAY_W-1:0]  way;
    logic              hit;
  } access_t;

  typedef enum int {LEAN_NONE, LEAN_SRRIP, LEAN_BRRIP} lean_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  localparam int POOL_SIZE = 6;
  localparam int LEAN_PCT  = 95;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = OP_VICTIM;
  logic [SET_W-1:0]    in_set_index = '0;
  logic [WAY_W-1:0]    in_way_index = '0;
  logic                in_was_hit = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VICTIM_W-1:0] out_victim_way;

  drrip_cache_replacement_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_set_index   (in_set_index),
    .in_way_index   (in_way_index),
    .in_was_hit     (in_was_hit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_victim_way (out_victim_way)
  );

  // predictor state
  logic [RRPV_W-1:0] rrpv_tab [NUM_SETS][NUM_WAYS];
  logic [SEL_W-1:0]  psel_cnt;

  access_t             access_queue [$];
  logic [VICTIM_W-1:0] victim_expected [$];
  int                  mismatch_count = 0;
  bit                  req_taken = 1'b0;
  access_t             seen_req;
  access_t             next_req;
  int                  burst_left = 0;
  int                  gap_left = 0;
  stall_mode_t         stall_mode = STALL_NONE;
  int                  mode_left = 0;
  int unsigned         set_pool [POOL_SIZE];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit is_srrip_set(int unsigned s);
    return (s / STRIDE) < LEADER_SETS && (s % STRIDE) == 0;
  endfunction

  function automatic bit is_brrip_set(int unsigned s);
    return (s / STRIDE) < LEADER_SETS && (s % STRIDE) == STRIDE_MID;
  endfunction

  task automatic reset_predictor();
    for (int s = 0; s < NUM_SETS; s++)
      for (int w = 0; w < NUM_WAYS; w++)
        rrpv_tab[s][w] = RRPV_SAT;
    psel_cnt = SEL_HALF;
  endtask

  task automatic predict_access(input access_t a);
    int unsigned s;
    int unsigned w;
    logic [RRPV_W-1:0] top;
    logic [RRPV_W-1:0] lift;
    logic [VICTIM_W-1:0] victim;
    bit found;
    s = int'(a.set) % NUM_SETS;
    w = a.way;
    if (a.op == OP_VICTIM) begin
      top = '0;
      for (int i = 0; i < NUM_WAYS; i++)
        if (rrpv_tab[s][i] > top) top = rrpv_tab[s][i];
      // age the whole set so the oldest way reaches the maximum
      if (top < RRPV_SAT) begin
        lift = RRPV_SAT - top;
        for (int i = 0; i < NUM_WAYS; i++)
          rrpv_tab[s][i] = rrpv_tab[s][i] + lift;
      end
      victim = '0;
      found = 1'b0;
      for (int i = 0; i < NUM_WAYS; i++) begin
        if (!found && rrpv_tab[s][i] == RRPV_SAT) begin
          victim = VICTIM_W'(i);
          found = 1'b1;
        end
      end
      victim_expected.push_back(victim);
    end else if (w < NUM_WAYS) begin
      if (a.hit) begin
        rrpv_tab[s][w] = '0;
        if (is_srrip_set(s) && psel_cnt < SEL_MAX) psel_cnt = psel_cnt + 1'b1;
        if (is_brrip_set(s) && psel_cnt > 0) psel_cnt = psel_cnt - 1'b1;
      end else if (is_srrip_set(s)) begin
        rrpv_tab[s][w] = '0;
      end else if (is_brrip_set(s)) begin
        rrpv_tab[s][w] = RRPV_LONG;
      end else begin
        rrpv_tab[s][w] = (psel_cnt >= SEL_HALF) ? '0 : RRPV_LONG;
      end
    end
  endtask

  task automatic add_req(input logic op, input int unsigned s, input int unsigned w,
                         input logic hit);
    access_t a;
    a.op  = op;
    a.set = SET_W'(s);
    a.way = WAY_W'(w);
    a.hit = hit;
    access_queue.push_back(a);
  endtask

  function automatic int unsigned leader_set(bit brrip);
    int unsigned k;
    k = $urandom_range(0, LEADER_SETS - 1);
    return brrip ? k * STRIDE + STRIDE_MID : k * STRIDE;
  endfunction

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE - 2; i++)
      set_pool[i] = $urandom_range(0, NUM_SETS - 1);
    set_pool[POOL_SIZE-2] = leader_set(1'b0);
    set_pool[POOL_SIZE-1] = leader_set(1'b1);
  endtask

  // lean phases push the selector toward one saturation limit via leader hits
  task automatic queue_random(input int count, input lean_t lean);
    access_t a;
    int r;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) refresh_pool();
      a.way = WAY_W'($urandom);
      a.hit = $urandom_range(0, 1);
      a.set = SET_W'(set_pool[$urandom_range(0, POOL_SIZE - 1)]);
      r = $urandom_range(0, 99);
      if (lean != LEAN_NONE && r < LEAN_PCT) begin
        a.op  = OP_UPDATE;
        a.hit = 1'b1;
        a.set = SET_W'(leader_set(lean == LEAN_BRRIP));
      end else begin
        a.op = ($urandom_range(0, 99) < 35) ? OP_VICTIM : OP_UPDATE;
        if ($urandom_range(0, 19) == 0) a.set = SET_W'($urandom);
      end
      access_queue.push_back(a);
    end
  endtask

  // sender: bursts with random gaps, payload held while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (access_queue.size() > 0) begin
        next_req = access_queue.pop_front();
        in_operation <= next_req.op;
        in_set_index <= next_req.set;
        in_way_index <= next_req.way;
        in_was_hit   <= next_req.hit;
        in_valid     <= 1'b1;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between modes every so often
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 200);
    end else begin
      mode_left = mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 99) < 75);
      default:      out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken = 1'b0;
    end else begin
      req_taken = in_valid && (in_stall === 1'b0);
      if (req_taken) begin
        seen_req.op  = in_operation;
        seen_req.set = in_set_index;
        seen_req.way = in_way_index;
        seen_req.hit = in_was_hit;
        predict_access(seen_req);
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (victim_expected.size() == 0) begin
          $error("victim_way: no result expected, got %0d", out_victim_way);
          mismatch_count++;
        end else if (out_victim_way !== victim_expected[0]) begin
          $error("victim_way: expected %0d, got %0d", victim_expected[0], out_victim_way);
          mismatch_count++;
          void'(victim_expected.pop_front());
        end else begin
          void'(victim_expected.pop_front());
        end
      end
    end
  end

  initial begin
    reset_predictor();

    // fresh sets at both ends of the index range
    add_req(OP_VICTIM, 0, 0, 1'b0);
    add_req(OP_VICTIM, NUM_SETS - 1, 15, 1'b1);
    // hits in both leader kinds move the selector
    add_req(OP_UPDATE, 0, 0, 1'b1);
    add_req(OP_UPDATE, STRIDE_MID, 15, 1'b1);
    // fills in follower, brrip leader and srrip leader sets
    add_req(OP_UPDATE, NUM_SETS - 1, 15, 1'b0);
    add_req(OP_UPDATE, STRIDE_MID, 3, 1'b0);
    add_req(OP_UPDATE, STRIDE, 0, 1'b0);
    // every way recently used, so the victim search must age the set fully
    for (int w = 0; w < NUM_WAYS; w++)
      add_req(OP_UPDATE, 5, w, 1'b1);
    add_req(OP_VICTIM, 5, 0, 1'b0);

    queue_random(150, LEAN_NONE);
    queue_random(600, LEAN_SRRIP);
    queue_random(1150, LEAN_BRRIP);
    queue_random(100, LEAN_NONE);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (access_queue.size() != 0 || in_valid) @(posedge clk);
    while (victim_expected.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && victim_expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> drrip_cache_replacement_core.f
rtl/drrip_pkg.sv
rtl/drrip_datapath.sv
rtl/drrip_ctrl.sv
rtl/drrip_cache_replacement_core.sv
sim/drrip_cache_replacement_core_tb.sv
